// File: hw/rtl/bipp_pkg.sv
`default_nettype none
package bipp_pkg;

  localparam int WORD_BITS = 32;
  localparam int COUNT_W   = 11;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'h7FF;

  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_ROW_FIRST    = 3'd2;
  localparam logic [2:0] REG_ROW_LAST     = 3'd3;
  localparam logic [2:0] REG_COL_FIRST    = 3'd4;
  localparam logic [2:0] REG_COL_LAST     = 3'd5;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic KIND_ROW    = 1'b0;
  localparam logic KIND_COLUMN = 1'b1;

  typedef struct packed {
    logic [10:0] image_width;
    logic [10:0] image_height;
    logic [9:0]  row_first;
    logic [9:0]  row_last;
    logic [9:0]  col_first;
    logic [9:0]  col_last;
  } cfg_t;

  typedef struct packed {
    logic               result_kind;
    logic [9:0]         line_index;
    logic [COUNT_W-1:0] black_count;
    logic               frame_end;
    logic               window_bad;
  } out_item_t;

  typedef struct packed {
    logic                 is_read;
    logic                 has_result;
    logic [4:0]           lane;
    logic                 col_ok;
    logic                 row0;
    logic                 in_rows;
    logic [WORD_BITS-1:0] black;
    logic [WORD_BITS-1:0] lanes_ok;
    out_item_t            item;
  } req_t;

endpackage
`default_nettype wire

// File: hw/rtl/bipp_cfg.sv
`default_nettype none
module bipp_cfg (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [4:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic      [31:0]     prdata,
  output logic                 pready,
  output bipp_pkg::cfg_t       cfg
);

  bipp_pkg::cfg_t cfg_r;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= 11'd1024;
      cfg_r.image_height <= 11'd1024;
      cfg_r.row_first    <= 10'd0;
      cfg_r.row_last     <= 10'd1023;
      cfg_r.col_first    <= 10'd0;
      cfg_r.col_last     <= 10'd1023;
    end else if (wr_en) begin
      case (idx)
        bipp_pkg::REG_IMAGE_WIDTH:  cfg_r.image_width  <= pwdata[10:0];
        bipp_pkg::REG_IMAGE_HEIGHT: cfg_r.image_height <= pwdata[10:0];
        bipp_pkg::REG_ROW_FIRST:    cfg_r.row_first    <= pwdata[9:0];
        bipp_pkg::REG_ROW_LAST:     cfg_r.row_last     <= pwdata[9:0];
        bipp_pkg::REG_COL_FIRST:    cfg_r.col_first    <= pwdata[9:0];
        bipp_pkg::REG_COL_LAST:     cfg_r.col_last     <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bipp_pkg::REG_IMAGE_WIDTH:  prdata = {21'd0, cfg_r.image_width};
      bipp_pkg::REG_IMAGE_HEIGHT: prdata = {21'd0, cfg_r.image_height};
      bipp_pkg::REG_ROW_FIRST:    prdata = {22'd0, cfg_r.row_first};
      bipp_pkg::REG_ROW_LAST:     prdata = {22'd0, cfg_r.row_last};
      bipp_pkg::REG_COL_FIRST:    prdata = {22'd0, cfg_r.col_first};
      bipp_pkg::REG_COL_LAST:     prdata = {22'd0, cfg_r.col_last};
      default:                    prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/bipp_front.sv
`default_nettype none
module bipp_front #(
  parameter int  MAX_WIDTH  = 1024,
  parameter int  MAX_HEIGHT = 1024,
  localparam int WORDS = (MAX_WIDTH + bipp_pkg::WORD_BITS - 1) / bipp_pkg::WORD_BITS,
  localparam int WIW   = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire bipp_pkg::cfg_t       cfg,
  input  wire logic                 accept,
  input  wire logic                 command,
  input  wire logic [31:0]          pixel_word,
  input  wire logic [9:0]           column_index,
  output bipp_pkg::req_t            req,
  output logic [WIW-1:0]            addr
);

  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CW    = (WIW + 5 > 11) ? WIW + 5 : 11;
  localparam int HW    = ((RW > 11) ? RW : 11) + 1;

  logic [WIW-1:0]                   word_in_row_r, word_in_row_nxt;
  logic [RW-1:0]                    row_number_r, row_number_nxt;
  logic [bipp_pkg::COUNT_W-1:0]     row_acc_r, row_acc_nxt;

  logic [10:0] w, h, w_m1, cend;
  logic        rbad, cbad, in_rows, row_end, last;
  logic [6:0]  words;
  logic [31:0] lanes_ok, black, row_mask;
  logic [5:0]  pc;
  logic [11:0] sum;
  logic [bipp_pkg::COUNT_W-1:0] acc_new;

  always_comb begin
    if (cfg.image_width == 11'd0) w = 11'd1;
    else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) w = 11'(MAX_WIDTH);
    else w = cfg.image_width;
    if (cfg.image_height == 11'd0) h = 11'd1;
    else if (32'(cfg.image_height) > 32'(MAX_HEIGHT)) h = 11'(MAX_HEIGHT);
    else h = cfg.image_height;
  end

  assign w_m1  = w - 11'd1;
  assign cend  = ({1'b0, cfg.col_last} < w_m1) ? {1'b0, cfg.col_last} : w_m1;
  assign rbad  = (cfg.row_last < cfg.row_first) || ({1'b0, cfg.row_last} >= h);
  assign cbad  = ({1'b0, cfg.col_first} >= w) || (cfg.col_first > cfg.col_last);
  assign in_rows = !rbad && (HW'(row_number_r) >= HW'(cfg.row_first))
                         && (HW'(row_number_r) <= HW'(cfg.row_last));
  assign words   = 7'((12'(w) + 12'd31) >> 5);
  assign row_end = (8'(word_in_row_r) + 8'd1) >= {1'b0, words};
  assign last    = (HW'(row_number_r) + HW'(1)) >= HW'(h);

  always_comb begin
    logic [CW-1:0] col;
    for (int k = 0; k < bipp_pkg::WORD_BITS; k++) begin
      col         = CW'({word_in_row_r, 5'(k)});
      lanes_ok[k] = col < CW'(w);
      black[k]    = !pixel_word[k] && lanes_ok[k];
      row_mask[k] = black[k] && !cbad && (col >= CW'(cfg.col_first)) && (col <= CW'(cend));
    end
  end

  assign pc      = 6'($countones(row_mask));
  assign sum     = 12'(row_acc_r) + 12'(pc);
  assign acc_new = (sum > 12'(bipp_pkg::COUNT_MAX)) ? bipp_pkg::COUNT_MAX : sum[10:0];

  always_comb begin
    req.is_read  = (command == bipp_pkg::CMD_READ);
    req.lane     = column_index[4:0];
    req.col_ok   = !rbad && ({1'b0, column_index} < w);
    req.row0     = (row_number_r == '0);
    req.in_rows  = in_rows;
    req.black    = black;
    req.lanes_ok = lanes_ok;
    if (command == bipp_pkg::CMD_READ) begin
      req.has_result       = 1'b1;
      req.item.result_kind = bipp_pkg::KIND_COLUMN;
      req.item.line_index  = column_index;
      req.item.black_count = '0;
      req.item.frame_end   = 1'b0;
      req.item.window_bad  = rbad;
      addr                 = WIW'(column_index[9:5]);
    end else begin
      req.has_result       = row_end;
      req.item.result_kind = bipp_pkg::KIND_ROW;
      req.item.line_index  = 10'(row_number_r);
      req.item.black_count = cbad ? '0 : acc_new;
      req.item.frame_end   = last;
      req.item.window_bad  = cbad;
      addr                 = word_in_row_r;
    end
  end

  always_comb begin
    word_in_row_nxt = word_in_row_r;
    row_number_nxt  = row_number_r;
    row_acc_nxt     = row_acc_r;
    if (accept && command == bipp_pkg::CMD_PIXEL) begin
      if (row_end) begin
        word_in_row_nxt = '0;
        row_acc_nxt     = '0;
        row_number_nxt  = last ? '0 : row_number_r + RW'(1);
      end else begin
        word_in_row_nxt = word_in_row_r + WIW'(1);
        row_acc_nxt     = acc_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_in_row_r <= '0;
      row_number_r  <= '0;
      row_acc_r     <= '0;
    end else begin
      word_in_row_r <= word_in_row_nxt;
      row_number_r  <= row_number_nxt;
      row_acc_r     <= row_acc_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/bipp_colmem.sv
`default_nettype none
module bipp_colmem #(
  parameter int  MAX_WIDTH = 1024,
  localparam int WORDS = (MAX_WIDTH + bipp_pkg::WORD_BITS - 1) / bipp_pkg::WORD_BITS,
  localparam int WIW   = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 accept,
  input  wire logic                 advance,
  input  wire bipp_pkg::req_t       req,
  input  wire logic [WIW-1:0]       addr,
  output logic                      s1_valid,
  output logic                      s1_has_result,
  output bipp_pkg::out_item_t       s1_item
);

  typedef logic [bipp_pkg::WORD_BITS-1:0][bipp_pkg::COUNT_W-1:0] row_data_t;

  row_data_t      mem [WORDS];
  row_data_t      rdata_r, fwd_data_r, old_data, new_data;
  logic [WIW-1:0] s1_addr_r, fwd_addr_r;
  logic           s1_valid_r, fwd_valid_r, wr_en;
  bipp_pkg::req_t s1_req_r;

  // the read issued with this item missed the write made at the same edge
  assign old_data = (fwd_valid_r && fwd_addr_r == s1_addr_r) ? fwd_data_r : rdata_r;
  assign wr_en    = s1_valid_r && !s1_req_r.is_read && advance;

  always_comb begin
    logic [bipp_pkg::COUNT_W-1:0] base;
    for (int k = 0; k < bipp_pkg::WORD_BITS; k++) begin
      base = s1_req_r.row0 ? '0 : old_data[k];
      if (s1_req_r.in_rows && s1_req_r.black[k] && base != bipp_pkg::COUNT_MAX)
        base = base + bipp_pkg::COUNT_W'(1);
      new_data[k] = s1_req_r.lanes_ok[k] ? base : old_data[k];
    end
  end

  always_comb begin
    s1_item = s1_req_r.item;
    if (s1_req_r.is_read) begin
      s1_item.black_count = s1_req_r.col_ok ? old_data[s1_req_r.lane] : '0;
    end
  end

  assign s1_valid      = s1_valid_r;
  assign s1_has_result = s1_req_r.has_result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      if (advance) s1_valid_r <= accept;
      if (accept) fwd_valid_r <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req_r   <= req;
      s1_addr_r  <= addr;
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= new_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) rdata_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[s1_addr_r] <= new_data;
  end

endmodule
`default_nettype wire

// File: hw/rtl/binary_image_projection_profile_top.sv
// Binary image projection profile.
// in_*: one item per handshake. command 0 carries 32 pixels of the row-major
// image (0 = black); command 1 asks for the black count of column
// in_column_index. out_*: row counts at each row end (result_kind 0) and
// column count replies (result_kind 1). Only the last word of a row and read
// commands give a result; other words give none.
// Config registers sit on the APB port at 4*index; write them only while idle.
// One item per cycle while in_ready is high. A result passes the memory stage
// and output registers. Column counts live in a memory of one 32-counter row
// per pixel word, updated read-modify-write with a registered read; a
// forwarding register covers back-to-back items on the same word.
// Row counts are ready at the last word; column counts are complete once a
// full frame has passed, and row 0 writes them fresh.
// Reset returns the registers to their defaults and restarts at row 0, word 0.
// If out_ready stays low, one result waits in the output register and a
// second in the memory stage; in_ready then drops until the output moves.
`default_nettype none
module binary_image_projection_profile_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_command,
  input  wire logic [31:0] in_pixel_word,
  input  wire logic [9:0]  in_column_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_result_kind,
  output logic [9:0]       out_line_index,
  output logic [10:0]      out_black_count,
  output logic             out_frame_end,
  output logic             out_window_bad,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int WORDS = (MAX_WIDTH + bipp_pkg::WORD_BITS - 1) / bipp_pkg::WORD_BITS;
  localparam int WIW   = (WORDS > 1) ? $clog2(WORDS) : 1;

  bipp_pkg::cfg_t      cfg;
  bipp_pkg::req_t      req;
  bipp_pkg::out_item_t s1_item, out_item_r;
  logic [WIW-1:0]      addr;
  logic                s1_valid, s1_has_result, advance, accept, out_valid_r;

  assign advance  = !s1_valid || !s1_has_result || !out_valid_r || out_ready;
  assign in_ready = advance;
  assign accept   = in_valid && advance;

  bipp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bipp_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .accept       (accept),
    .command      (in_command),
    .pixel_word   (in_pixel_word),
    .column_index (in_column_index),
    .req          (req),
    .addr         (addr)
  );

  bipp_colmem #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_colmem (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .advance       (advance),
    .req           (req),
    .addr          (addr),
    .s1_valid      (s1_valid),
    .s1_has_result (s1_has_result),
    .s1_item       (s1_item)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && s1_valid && s1_has_result) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid && s1_has_result) out_item_r <= s1_item;
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_item_r.result_kind;
  assign out_line_index  = out_item_r.line_index;
  assign out_black_count = out_item_r.black_count;
  assign out_frame_end   = out_item_r.frame_end;
  assign out_window_bad  = out_item_r.window_bad;

endmodule
`default_nettype wire
